// ----- sv/zdsr_pkg.sv -----
`timescale 1ns / 1ps

package zdsr_pkg;

  // Hard cap on data bytes per subpacket; max_length is clamped to this.
  localparam int MaxSubpacket = 1024;

  localparam int KindW  = 3;
  localparam int ByteW  = 8;
  localparam int CountW = 11;
  localparam int CrcW   = 32;
  localparam int TrlW   = 3;

  localparam logic [CrcW-1:0]  Crc32Init    = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]  Crc32Residue = 32'hDEBB_20E3;
  localparam logic [CrcW-1:0]  Crc32Poly    = 32'hEDB8_8320;
  localparam logic [15:0]      Crc16Poly    = 16'h1021;
  localparam logic [TrlW-1:0]  Crc16Trailer = 3'd2;
  localparam logic [TrlW-1:0]  Crc32Trailer = 3'd4;

  typedef enum logic [KindW-1:0] {
    SYM_DATA      = 3'd0,
    SYM_FRAME_END = 3'd1,
    SYM_CANCEL    = 3'd2,
    SYM_TIMEOUT   = 3'd3,
    SYM_OTHER     = 3'd4
  } sym_kind_e;

  typedef enum logic [KindW-1:0] {
    RES_DATA      = 3'd0,
    RES_GOOD_END  = 3'd1,
    RES_BAD_CRC   = 3'd2,
    RES_CANCEL    = 3'd3,
    RES_TIMEOUT   = 3'd4,
    RES_BAD_SUB   = 3'd5,
    RES_TOO_LONG  = 3'd6
  } res_kind_e;

  typedef enum logic {
    CFG_CRC32_MODE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  value;
    logic [CountW-1:0] count;
  } res_t;

  // CRC-16/XMODEM, augmented form: shift message bits in at the bottom.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc,
                                             input logic [ByteW-1:0] b);
    logic [15:0] c;
    logic        top;
    c = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      top = c[15];
      c   = {c[14:0], b[i]};
      if (top) begin
        c = c ^ Crc16Poly;
      end
    end
    return c;
  endfunction

  // Reflected CRC-32, one byte.
  function automatic logic [CrcW-1:0] crc32_fold(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc32Poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/zmodem_data_subpacket_receiver.sv -----
`timescale 1ns / 1ps

// Channel | dir | handshake                | payload
// --------+-----+--------------------------+------------------------------------
// symbol  | in  | in_valid_i / in_stall_o  | sym_kind_i, sym_value_i
// result  | out | out_valid_o / out_stall_i| res_kind_o, res_value_o, byte_count_o
// config  | in  | cfg_we_i (no wait)       | cfg_index_i, cfg_data_i
//
// One symbol per cycle while in_stall_o is low. The CRC byte fold, limit compare
// and trailer count all sit between the subpacket state registers and the result
// register; a result goes to the skid entry instead while a held result is stalled.
// A two-entry output (result register + skid) keeps in_stall_o registered;
// intake stops only while both entries are full.
// rst_ni (async, active low) clears the subpacket state, CRC-16 mode,
// max_length = 1024, and both output entries. No clearing pass.

module zmodem_data_subpacket_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [zdsr_pkg::KindW-1:0]    sym_kind_i,
  input  logic [zdsr_pkg::ByteW-1:0]    sym_value_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [zdsr_pkg::KindW-1:0]    res_kind_o,
  output logic [zdsr_pkg::ByteW-1:0]    res_value_o,
  output logic [zdsr_pkg::CountW-1:0]   byte_count_o,

  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [zdsr_pkg::CountW-1:0]   cfg_data_i
);

  localparam logic [zdsr_pkg::CountW-1:0] MaxSub = zdsr_pkg::CountW'(zdsr_pkg::MaxSubpacket);

  // configuration
  logic                          crc32_mode_q;
  logic [zdsr_pkg::CountW-1:0]   max_length_q;

  // subpacket state
  logic [zdsr_pkg::CrcW-1:0]     crc_q, crc_d;
  logic                          in_trailer_q, in_trailer_d;
  logic [zdsr_pkg::TrlW-1:0]     trailer_left_q, trailer_left_d;
  logic [zdsr_pkg::ByteW-1:0]    end_char_q, end_char_d;
  logic [zdsr_pkg::CountW-1:0]   stored_count_q, stored_count_d;

  // output entries
  logic                          out_valid_q, skid_valid_q;
  zdsr_pkg::res_t                out_q, skid_q;

  logic                          in_fire, out_fire;
  logic                          res_valid;
  zdsr_pkg::res_t                res;
  logic [zdsr_pkg::CrcW-1:0]     crc_fold, crc_start;
  logic [zdsr_pkg::CountW-1:0]   limit;
  logic [zdsr_pkg::TrlW-1:0]     trl_dec;
  logic                          crc_ok;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign res_kind_o   = out_q.kind;
  assign res_value_o  = out_q.value;
  assign byte_count_o = out_q.count;

  assign crc_start = crc32_mode_q ? zdsr_pkg::Crc32Init : '0;
  assign crc_fold  = crc32_mode_q ? zdsr_pkg::crc32_fold(crc_q, sym_value_i)
                                  : {16'h0000, zdsr_pkg::crc16_fold(crc_q[15:0], sym_value_i)};
  assign limit     = (max_length_q < MaxSub) ? max_length_q : MaxSub;
  assign trl_dec   = trailer_left_q - 3'd1;
  assign crc_ok    = crc32_mode_q ? (crc_fold == zdsr_pkg::Crc32Residue)
                                  : (crc_fold[15:0] == 16'h0000);

  // Per-symbol decode. Every result other than data closes the subpacket.
  always_comb begin
    crc_d          = crc_q;
    in_trailer_d   = in_trailer_q;
    trailer_left_d = trailer_left_q;
    end_char_d     = end_char_q;
    stored_count_d = stored_count_q;
    res_valid      = 1'b0;
    res            = '0;

    case (zdsr_pkg::sym_kind_e'(sym_kind_i))
      zdsr_pkg::SYM_DATA: begin
        if (in_trailer_q) begin
          crc_d          = crc_fold;
          trailer_left_d = trl_dec;
          if (trl_dec == '0) begin
            res_valid = 1'b1;
            if (crc_ok) begin
              res.kind  = zdsr_pkg::RES_GOOD_END;
              res.value = end_char_q;
              res.count = stored_count_q;
            end else begin
              res.kind  = zdsr_pkg::RES_BAD_CRC;
            end
            crc_d          = crc_start;
            in_trailer_d   = 1'b0;
            end_char_d     = '0;
            stored_count_d = '0;
          end
        end else if (stored_count_q >= limit) begin
          res_valid      = 1'b1;
          res.kind       = zdsr_pkg::RES_TOO_LONG;
          crc_d          = crc_start;
          trailer_left_d = '0;
          end_char_d     = '0;
          stored_count_d = '0;
        end else begin
          res_valid      = 1'b1;
          res.kind       = zdsr_pkg::RES_DATA;
          res.value      = sym_value_i;
          res.count      = stored_count_q;
          crc_d          = crc_fold;
          stored_count_d = stored_count_q + 11'd1;
        end
      end
      zdsr_pkg::SYM_FRAME_END: begin
        // also restarts the check byte count if seen inside the trailer
        crc_d          = crc_fold;
        end_char_d     = sym_value_i;
        in_trailer_d   = 1'b1;
        trailer_left_d = crc32_mode_q ? zdsr_pkg::Crc32Trailer : zdsr_pkg::Crc16Trailer;
      end
      default: begin
        res_valid      = 1'b1;
        if (zdsr_pkg::sym_kind_e'(sym_kind_i) == zdsr_pkg::SYM_CANCEL) begin
          res.kind = zdsr_pkg::RES_CANCEL;
        end else if (zdsr_pkg::sym_kind_e'(sym_kind_i) == zdsr_pkg::SYM_TIMEOUT) begin
          res.kind = zdsr_pkg::RES_TIMEOUT;
        end else begin
          res.kind = zdsr_pkg::RES_BAD_SUB;
        end
        crc_d          = crc_start;
        in_trailer_d   = 1'b0;
        trailer_left_d = '0;
        end_char_d     = '0;
        stored_count_d = '0;
      end
    endcase
  end

  // Configuration and subpacket state. A mode write restarts the subpacket.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc32_mode_q   <= 1'b0;
      max_length_q   <= 11'd1024;
      crc_q          <= '0;
      in_trailer_q   <= 1'b0;
      trailer_left_q <= '0;
      end_char_q     <= '0;
      stored_count_q <= '0;
    end else if (cfg_we_i) begin
      case (zdsr_pkg::cfg_index_e'(cfg_index_i))
        zdsr_pkg::CFG_CRC32_MODE: begin
          crc32_mode_q   <= cfg_data_i[0];
          crc_q          <= cfg_data_i[0] ? zdsr_pkg::Crc32Init : '0;
          in_trailer_q   <= 1'b0;
          trailer_left_q <= '0;
          end_char_q     <= '0;
          stored_count_q <= '0;
        end
        zdsr_pkg::CFG_MAX_LENGTH: begin
          max_length_q <= cfg_data_i;
        end
        default: begin
          max_length_q <= max_length_q;
        end
      endcase
    end else if (in_fire) begin
      crc_q          <= crc_d;
      in_trailer_q   <= in_trailer_d;
      trailer_left_q <= trailer_left_d;
      end_char_q     <= end_char_d;
      stored_count_q <= stored_count_d;
    end
  end

  // Result register plus skid entry; skid drains into the result register first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // skid only fills behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without result entry");

  // trailer flag and check byte count move together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_trailer_q == (trailer_left_q != '0))
    else $error("trailer flag and count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_count_q <= MaxSub)
    else $error("stored byte count beyond hard cap");

  // a result in the skid entry leaves the result register unchanged while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> (skid_valid_q && $stable(out_q)))
    else $error("held result lost while skid entry full");

endmodule

// ----- sim/zdsr_subpacket_checker.sv -----
`timescale 1ns / 1ps

// CRC byte step shared by the checker (prediction) and the stimulus (check bytes).
package zdsr_crc_tb_pkg;
  import zdsr_pkg::*;

  function automatic logic [CrcW-1:0] crc_step(input logic use32,
                                               input logic [CrcW-1:0] r,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] acc;
    logic            carry;
    acc = r;
    if (use32) begin
      acc = acc ^ {{(CrcW-ByteW){1'b0}}, b};
      repeat (ByteW) acc = acc[0] ? ((acc >> 1) ^ Crc32Poly) : (acc >> 1);
    end else begin
      acc[CrcW-1:16] = '0;
      for (int n = ByteW - 1; n >= 0; n--) begin
        carry      = acc[15];
        acc[15:0]  = {acc[14:0], b[n]};
        if (carry) begin
          acc[15:0] = acc[15:0] ^ Crc16Poly;
        end
      end
    end
    return acc;
  endfunction

endpackage

module zdsr_subpacket_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sym_valid_i,
  input  logic                 sym_stall_i,
  input  logic [2:0]           sym_kind_i,
  input  logic [7:0]           sym_value_i,
  input  logic                 res_valid_i,
  input  logic                 res_stall_i,
  input  logic [2:0]           res_kind_i,
  input  logic [7:0]           res_value_i,
  input  logic [10:0]          byte_count_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [10:0]          cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  import zdsr_pkg::*;
  import zdsr_crc_tb_pkg::*;

  localparam int MaxReports = 10;

  typedef struct {
    res_kind_e          kind;
    logic [ByteW-1:0]   value;
    logic [CountW-1:0]  count;
  } outcome_t;

  outcome_t           due_q[$];
  int                 errors = 0;

  // predicted block state
  logic               crc32_on;
  logic [CountW-1:0]  len_limit;
  logic [CrcW-1:0]    crc;
  logic               trailing;
  logic [TrlW-1:0]    chk_left;
  logic [ByteW-1:0]   end_char;
  logic [CountW-1:0]  stored;

  task automatic restart();
    crc      = crc32_on ? Crc32Init : '0;
    trailing = 1'b0;
    chk_left = '0;
    end_char = '0;
    stored   = '0;
  endtask

  task automatic push(input res_kind_e k, input logic [ByteW-1:0] v,
                      input logic [CountW-1:0] c);
    outcome_t o;
    o.kind  = k;
    o.value = v;
    o.count = c;
    due_q.push_back(o);
  endtask

  task automatic flag(input string what);
    errors++;
    if (errors <= MaxReports) begin
      $display("%0t zdsr check: %s", $time, what);
    end
  endtask

  task automatic decode_symbol(input logic [KindW-1:0] k, input logic [ByteW-1:0] v);
    logic [CountW-1:0] cap;
    logic              ok;
    cap = (len_limit < MaxSubpacket) ? len_limit : CountW'(MaxSubpacket);
    if (k == SYM_DATA) begin
      if (trailing) begin
        crc      = crc_step(crc32_on, crc, v);
        chk_left = chk_left - 1'b1;
        if (chk_left == '0) begin
          ok = crc32_on ? (crc == Crc32Residue) : (crc[15:0] == 16'h0);
          if (ok) begin
            push(RES_GOOD_END, end_char, stored);
          end else begin
            push(RES_BAD_CRC, '0, '0);
          end
          restart();
        end
      end else if (stored >= cap) begin
        restart();
        push(RES_TOO_LONG, '0, '0);
      end else begin
        crc = crc_step(crc32_on, crc, v);
        push(RES_DATA, v, stored);
        stored = stored + 1'b1;
      end
    end else if (k == SYM_FRAME_END) begin
      // also taken mid-trailer: new end char, trailer count restarts, CRC kept
      crc      = crc_step(crc32_on, crc, v);
      end_char = v;
      trailing = 1'b1;
      chk_left = crc32_on ? Crc32Trailer : Crc16Trailer;
    end else begin
      restart();
      case (k)
        SYM_CANCEL:  push(RES_CANCEL, '0, '0);
        SYM_TIMEOUT: push(RES_TIMEOUT, '0, '0);
        default:     push(RES_BAD_SUB, '0, '0);
      endcase
    end
  endtask

  always @(posedge clk_i) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      crc32_on  = 1'b0;
      len_limit = CountW'(MaxSubpacket);
      restart();
      due_q.delete();
    end else begin
      // results first: an item taken at this edge cannot have its result here
      if (res_valid_i && !res_stall_i) begin
        if (due_q.size() == 0) begin
          flag($sformatf("result with nothing due: kind %0d value %02h count %0d",
                         res_kind_i, res_value_i, byte_count_i));
        end else begin
          want = due_q.pop_front();
          if (res_kind_i !== want.kind || res_value_i !== want.value ||
              byte_count_i !== want.count) begin
            flag($sformatf("expected kind %s value %02h count %0d, got kind %0d value %02h count %0d",
                           want.kind.name(), want.value, want.count,
                           res_kind_i, res_value_i, byte_count_i));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CRC32_MODE) begin
          crc32_on = cfg_data_i[0];
          restart();
        end else begin
          len_limit = cfg_data_i;
        end
      end
      if (sym_valid_i && !sym_stall_i) begin
        decode_symbol(sym_kind_i, sym_value_i);
      end
    end
    errors_o  <= errors;
    pending_o <= due_q.size();
  end

endmodule

// ----- sim/zmodem_data_subpacket_receiver_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict. Prediction and compare live in zdsr_subpacket_checker.
module zmodem_data_subpacket_receiver_tb;
  import zdsr_pkg::*;
  import zdsr_crc_tb_pkg::*;

  localparam int ClkPeriod    = 12;
  localparam int ResetCycles  = 9;
  localparam int SettleCycles = 6;         // result reg + skid, with margin
  localparam int RandomItems  = 360;
  localparam int PhaseItems   = 50;
  localparam int SqueezeLen   = 150;       // long receiver hold-off
  localparam int LimitNs      = 5_000_000;

  // kinds 5..7 are undefined and must act like "other special"
  localparam logic [KindW-1:0] KindUndef = 3'd7;

  typedef enum int {TAIL_GOOD, TAIL_BAD, TAIL_RESTART, TAIL_ABORT} tail_e;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [KindW-1:0]   sym_kind_i   = '0;
  logic [ByteW-1:0]   sym_value_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [KindW-1:0]   res_kind_o;
  logic [ByteW-1:0]   res_value_o;
  logic [CountW-1:0]  byte_count_o;
  logic               cfg_we_i     = 1'b0;
  logic               cfg_index_i  = CFG_CRC32_MODE;
  logic [CountW-1:0]  cfg_data_i   = '0;

  int                 errors;
  int                 pending;

  // stimulus-side view of the configuration
  logic               mode32  = 1'b0;
  int                 len_cap = MaxSubpacket;
  bit                 dirty   = 1'b0;      // block may be mid-subpacket after noise
  int                 sent    = 0;

  // shared with the receiver process, written only by NBA
  logic               calm    = 1'b0;      // no idling on either side
  logic               squeeze = 1'b0;      // ask for one long receiver hold-off
  logic               squeezed = 1'b0;
  int                 hold_left = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  zmodem_data_subpacket_receiver u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sym_kind_i   (sym_kind_i),
    .sym_value_i  (sym_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_kind_o   (res_kind_o),
    .res_value_o  (res_value_o),
    .byte_count_o (byte_count_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  zdsr_subpacket_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_valid_i  (in_valid_i),
    .sym_stall_i  (in_stall_o),
    .sym_kind_i   (sym_kind_i),
    .sym_value_i  (sym_value_i),
    .res_valid_i  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_kind_i   (res_kind_o),
    .res_value_i  (res_value_o),
    .byte_count_i (byte_count_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Receiver: random stalls about 30% of cycles, none while calm, and one long
  // hold-off on request so the two-entry output fills and in_stall_o rises.
  always @(posedge clk_i) begin
    if (squeeze && !squeezed) begin
      squeezed    <= 1'b1;
      hold_left   <= SqueezeLen;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  // Hard stop in case the block hangs or swallows results.
  initial begin
    #(LimitNs);
    $display("zmodem_data_subpacket_receiver_tb: errors");
    $finish;
  end

  // Mostly random bytes, with the two extremes showing up often.
  function automatic logic [ByteW-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ByteW'($urandom_range(0, 255));
  endfunction

  // One item. Random idle cycles before it; valid stays up between back-to-back
  // items. Returns at the edge that takes the item.
  task automatic send_sym(input logic [KindW-1:0] k, input logic [ByteW-1:0] v);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sym_kind_i  <= k;
    sym_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Well-formed subpacket: len data bytes, frame end, then a trailer shaped by
  // tail. Check bytes are computed so that a clean trailer passes:
  //   CRC-16 augmented: append the CRC of the message (two zero bytes folded),
  //   high byte first. CRC-32: append ~crc little-endian, giving the residue.
  task automatic send_packet(input int len, input tail_e tail);
    logic [CrcW-1:0]  crc;
    logic [CrcW-1:0]  fin;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] chk [4];
    logic [1:0]       sel;
    int               nchk;
    crc  = mode32 ? Crc32Init : '0;
    nchk = mode32 ? 4 : 2;
    repeat (len) begin
      b   = pick_byte();
      crc = crc_step(mode32, crc, b);
      send_sym(SYM_DATA, b);
    end
    b   = pick_byte();
    crc = crc_step(mode32, crc, b);
    send_sym(SYM_FRAME_END, b);
    case (tail)
      TAIL_ABORT: begin
        // a few check bytes, then a special code ends the subpacket
        repeat ($urandom_range(0, nchk - 1)) send_sym(SYM_DATA, pick_byte());
        send_sym(KindW'($urandom_range(SYM_CANCEL, KindUndef)), pick_byte());
        return;
      end
      TAIL_RESTART: begin
        // frame end inside the trailer: CRC keeps running, count restarts
        repeat ($urandom_range(0, nchk - 1)) begin
          b   = pick_byte();
          crc = crc_step(mode32, crc, b);
          send_sym(SYM_DATA, b);
        end
        b   = pick_byte();
        crc = crc_step(mode32, crc, b);
        send_sym(SYM_FRAME_END, b);
      end
      default: ;
    endcase
    if (mode32) begin
      fin    = ~crc;
      chk[0] = fin[7:0];
      chk[1] = fin[15:8];
      chk[2] = fin[23:16];
      chk[3] = fin[31:24];
    end else begin
      fin    = crc_step(1'b0, crc_step(1'b0, crc, '0), '0);
      chk[0] = fin[15:8];
      chk[1] = fin[7:0];
    end
    if (tail == TAIL_BAD) begin
      sel = 2'($urandom_range(0, nchk - 1));
      chk[sel] = chk[sel] ^ (8'h01 << $urandom_range(0, ByteW - 1));
    end
    for (int i = 0; i < nchk; i++) send_sym(SYM_DATA, chk[i]);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle:
  // a trailing item with no result may still be inside the block.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes, only when drained. A mode write restarts the subpacket.
  // Upper data bits of the mode write are random; only bit 0 counts.
  task automatic set_config(input bit touch_mode, input logic new_mode,
                            input logic [CountW-1:0] new_len);
    logic [CountW-1:0] word;
    if (touch_mode) begin
      word        = CountW'($urandom);
      word[0]     = new_mode;
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_CRC32_MODE;
      cfg_data_i  <= word;
      @(posedge clk_i);
      mode32 = new_mode;
      dirty  = 1'b0;
    end
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MAX_LENGTH;
    cfg_data_i  <= new_len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_cap  = (new_len < MaxSubpacket) ? new_len : MaxSubpacket;
  endtask

  // Random traffic: mostly well-formed subpackets with random content and
  // trailer shape, the rest short bursts of raw symbols of any kind.
  task automatic run_phase(input int quota);
    int first;
    int roll;
    int len;
    int hi;
    tail_e tail;
    first = sent;
    while (sent - first < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        // noise may have left a subpacket open; close it with a special code
        if (dirty) begin
          send_sym(KindW'($urandom_range(SYM_CANCEL, KindUndef)), pick_byte());
          dirty = 1'b0;
        end
        hi  = (len_cap < 24) ? len_cap : 24;
        len = $urandom_range(0, hi);
        if (len_cap < 24 && $urandom_range(0, 9) == 0) len = len_cap + 1;  // too long
        roll = $urandom_range(0, 99);
        if (roll < 50)      tail = TAIL_GOOD;
        else if (roll < 70) tail = TAIL_BAD;
        else if (roll < 85) tail = TAIL_RESTART;
        else                tail = TAIL_ABORT;
        send_packet(len, tail);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_sym(KindW'($urandom_range(0, 7)), ByteW'($urandom));
        end
        dirty = 1'b1;
      end
    end
  endtask

  initial begin
    int               phase;
    int               rand_first;
    int               pick;
    bit               touch;
    logic [CountW-1:0] new_len;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: reset config is CRC-16, max_length 1024 ---
    send_packet(2, TAIL_GOOD);
    send_packet(0, TAIL_BAD);              // frame end with no data
    send_packet(1, TAIL_RESTART);
    send_sym(SYM_CANCEL, '1);
    send_sym(SYM_TIMEOUT, '0);
    send_sym(SYM_OTHER, pick_byte());
    send_sym(KindUndef, pick_byte());
    drain();
    set_config(1'b1, 1'b1, '0);            // CRC-32, zero-length limit
    send_sym(SYM_DATA, 8'hA5);             // first byte is already too long
    drain();
    set_config(1'b0, 1'b0, 11'd3);
    send_packet(1, TAIL_GOOD);
    drain();

    // --- random phases, config rewritten between them ---
    phase      = 0;
    rand_first = sent;
    while (sent - rand_first < RandomItems) begin
      if (phase != 0) drain();
      pick = $urandom_range(0, 5);
      case (pick)
        0:       new_len = '0;
        1:       new_len = 11'd1;
        2:       new_len = CountW'(MaxSubpacket);
        3:       new_len = '1;
        4:       new_len = CountW'($urandom_range(0, 2047));
        default: new_len = CountW'($urandom_range(2, 30));
      endcase
      touch = (phase == 0) || ($urandom_range(0, 1) == 1);
      set_config(touch, 1'($urandom_range(0, 1)), new_len);
      if (phase == 1) squeeze <= 1'b1;     // long hold-off while items keep coming
      calm <= (phase == 2);
      run_phase(PhaseItems);
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("zmodem_data_subpacket_receiver_tb: clean");
    end else begin
      $display("zmodem_data_subpacket_receiver_tb: errors");
    end
    $finish;
  end

endmodule
